// ----- design/bhd_pkg.sv -----
package bhd_pkg;

    localparam int NODES_DEF = 64;
    localparam int IDX_W     = 6;
    localparam int FUNC_W    = 2;
    localparam int VAL_W     = 6;

    localparam logic [VAL_W-1:0] MAX_STEPS_RST = 6'd6;

    localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd0;
    localparam logic [FUNC_W-1:0] FN_ADD   = 2'd1;
    localparam logic [FUNC_W-1:0] FN_RUN   = 2'd2;
    localparam logic [FUNC_W-1:0] FN_READ  = 2'd3;

    // classified command as it sits in the front queue
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [IDX_W-1:0]  src;
        logic [IDX_W-1:0]  dst;
        logic              in_range;
    } t_cmd;

endpackage

// ----- design/bhd_if.sv -----
interface bhd_cmd_if import bhd_pkg::*;;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  src_node;
    logic [IDX_W-1:0]  dst_node;

    modport source (output valid, func, src_node, dst_node, input ready);
    modport sink   (input valid, func, src_node, dst_node, output ready);
endinterface

interface bhd_res_if import bhd_pkg::*;;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] kind;
    logic [VAL_W-1:0]  value;

    modport source (output valid, kind, value, input ready);
    modport sink   (input valid, kind, value, output ready);
endinterface

// ----- design/bhd_ram.sv -----
module bhd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/bhd_front.sv -----
module bhd_front import bhd_pkg::*; #(
    parameter int NODES = NODES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bhd_cmd_if.sink   i_cmd,
    input  logic      i_pop,
    output logic      o_q_valid,
    output t_cmd      o_q_cmd
);

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    t_cmd       w_cmd;

    assign i_cmd.ready = (r_cnt != 2'd2);
    assign w_push      = i_cmd.valid && i_cmd.ready;

    always_comb begin
        w_cmd.func     = i_cmd.func;
        w_cmd.src      = i_cmd.src_node;
        w_cmd.dst      = i_cmd.dst_node;
        w_cmd.in_range = (int'(i_cmd.src_node) < NODES) && (int'(i_cmd.dst_node) < NODES);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_cmd   = r_q[r_rp];

endmodule

// ----- design/bhd_back.sv -----
module bhd_back import bhd_pkg::*; #(
    parameter int NODES = NODES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [VAL_W-1:0] i_max_steps,
    input  logic             i_q_valid,
    input  t_cmd             i_q_cmd,
    output logic             o_pop,
    bhd_res_if.source        o_res
);

    localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int HW = 2 * IW;
    localparam logic [IW-1:0] LAST = IW'(NODES - 1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_EXEC     = 4'd1;
    localparam logic [3:0] S_ADD_W    = 4'd2;
    localparam logic [3:0] S_READ_W   = 4'd3;
    localparam logic [3:0] S_ROW_RD   = 4'd4;
    localparam logic [3:0] S_ROW_LAT  = 4'd5;
    localparam logic [3:0] S_K        = 4'd6;
    localparam logic [3:0] S_K_TAIL   = 4'd7;
    localparam logic [3:0] S_PASS_END = 4'd8;
    localparam logic [3:0] S_RESP     = 4'd9;

    logic [3:0]       r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    logic [VAL_W-1:0] r_pass, n_pass;
    logic             r_changed, n_changed;
    logic [IW-1:0]    r_r, n_r, r_k, n_k, r_kd, n_kd;
    logic             r_kd_v, n_kd_v;
    logic [NODES-1:0] r_row, n_row, r_new, n_new, r_acc, n_acc;
    logic [NODES-1:0] r_adj_v, n_adj_v;
    logic             r_hop_v, n_hop_v;
    logic [VAL_W-1:0] r_val, n_val;
    logic             r_o_valid, n_o_valid;
    logic [FUNC_W-1:0] r_o_kind, n_o_kind;
    logic [VAL_W-1:0] r_o_value, n_o_value;

    // memory ports
    logic             adj_we, reach_we, vis_we, hop_we;
    logic [IW-1:0]    adj_waddr, adj_raddr, reach_waddr, reach_raddr, vis_waddr, vis_raddr;
    logic [NODES-1:0] adj_wdata, adj_rdata, reach_wdata, reach_rdata, vis_wdata, vis_rdata;
    logic [HW-1:0]    hop_waddr, hop_raddr;
    logic [VAL_W-1:0] hop_wdata, hop_rdata;

    logic [IW-1:0] src_i, dst_i;
    assign src_i = IW'(r_cmd.src);
    assign dst_i = IW'(r_cmd.dst);

    bhd_ram #(.WIDTH(NODES), .DEPTH(NODES)) u_adj (
        .i_clk(i_clk), .i_we(adj_we), .i_waddr(adj_waddr), .i_wdata(adj_wdata),
        .i_raddr(adj_raddr), .o_rdata(adj_rdata)
    );
    bhd_ram #(.WIDTH(NODES), .DEPTH(NODES)) u_reach (
        .i_clk(i_clk), .i_we(reach_we), .i_waddr(reach_waddr), .i_wdata(reach_wdata),
        .i_raddr(reach_raddr), .o_rdata(reach_rdata)
    );
    bhd_ram #(.WIDTH(NODES), .DEPTH(NODES)) u_vis (
        .i_clk(i_clk), .i_we(vis_we), .i_waddr(vis_waddr), .i_wdata(vis_wdata),
        .i_raddr(vis_raddr), .o_rdata(vis_rdata)
    );
    bhd_ram #(.WIDTH(VAL_W), .DEPTH(NODES << IW)) u_hop (
        .i_clk(i_clk), .i_we(hop_we), .i_waddr(hop_waddr), .i_wdata(hop_wdata),
        .i_raddr(hop_raddr), .o_rdata(hop_rdata)
    );

    always_comb begin
        logic             first;
        logic [NODES-1:0] row_w, vis_w, new_w, acc_w;

        first = (r_pass == VAL_W'(1));
        row_w = '0;
        vis_w = '0;
        new_w = '0;
        acc_w = '0;

        n_state   = r_state;
        n_cmd     = r_cmd;
        n_pass    = r_pass;
        n_changed = r_changed;
        n_r       = r_r;
        n_k       = r_k;
        n_kd      = r_kd;
        n_kd_v    = r_kd_v;
        n_row     = r_row;
        n_new     = r_new;
        n_acc     = r_acc;
        n_adj_v   = r_adj_v;
        n_hop_v   = r_hop_v;
        n_val     = r_val;
        n_o_valid = r_o_valid;
        n_o_kind  = r_o_kind;
        n_o_value = r_o_value;
        o_pop     = 1'b0;

        adj_we = 1'b0;   adj_waddr = src_i;  adj_wdata = '0;  adj_raddr = r_r;
        reach_we = 1'b0; reach_waddr = r_r;  reach_wdata = '0; reach_raddr = r_r;
        vis_we = 1'b0;   vis_waddr = r_r;    vis_wdata = '0;  vis_raddr = r_r;
        hop_we = 1'b0;   hop_waddr = {r_r, r_k}; hop_wdata = '0;
        hop_raddr = {src_i, dst_i};

        if (r_o_valid && o_res.ready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                o_pop = i_q_valid;
                if (i_q_valid) begin
                    n_cmd   = i_q_cmd;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_val = '0;
                unique case (r_cmd.func)
                    FN_CLEAR: begin
                        n_adj_v = '0;
                        n_hop_v = 1'b0;
                        n_state = S_RESP;
                    end
                    FN_ADD: begin
                        adj_raddr = src_i;
                        n_state   = r_cmd.in_range ? S_ADD_W : S_RESP;
                    end
                    FN_RUN: begin
                        if (i_max_steps == '0) begin
                            n_hop_v = 1'b0;
                            n_state = S_RESP;
                        end else begin
                            // first pass writes every entry, so the store is valid after it
                            n_hop_v   = 1'b1;
                            n_pass    = VAL_W'(1);
                            n_changed = 1'b0;
                            n_r       = '0;
                            n_state   = S_ROW_RD;
                        end
                    end
                    FN_READ: begin
                        n_state = (r_cmd.in_range && r_hop_v) ? S_READ_W : S_RESP;
                    end
                    default: n_state = S_RESP;
                endcase
            end
            S_ADD_W: begin
                adj_we    = 1'b1;
                adj_wdata = (r_adj_v[src_i] ? adj_rdata : '0) | (NODES'(1) << dst_i);
                n_adj_v[src_i] = 1'b1;
                n_state   = S_RESP;
            end
            S_READ_W: begin
                n_val   = hop_rdata;
                n_state = S_RESP;
            end
            S_ROW_RD: begin
                n_state = S_ROW_LAT;
            end
            S_ROW_LAT: begin
                row_w = first ? (r_adj_v[r_r] ? adj_rdata : '0) : reach_rdata;
                vis_w = first ? '0 : vis_rdata;
                new_w = row_w & ~vis_w & ~(NODES'(1) << r_r);
                vis_we    = 1'b1;
                vis_wdata = vis_w | new_w;
                n_row  = row_w;
                n_new  = new_w;
                if (|new_w) begin
                    n_changed = 1'b1;
                end
                n_acc   = '0;
                n_k     = '0;
                n_kd_v  = 1'b0;
                n_state = S_K;
            end
            S_K: begin
                adj_raddr = r_k;
                hop_we    = first || r_new[r_k];
                hop_wdata = r_new[r_k] ? r_pass : '0;
                n_kd      = r_k;
                n_kd_v    = 1'b1;
                if (r_kd_v && r_row[r_kd] && r_adj_v[r_kd]) begin
                    n_acc = r_acc | adj_rdata;
                end
                if (r_k == LAST) begin
                    n_state = S_K_TAIL;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_K_TAIL: begin
                acc_w = r_acc | ((r_row[r_kd] && r_adj_v[r_kd]) ? adj_rdata : '0);
                reach_we    = 1'b1;
                reach_wdata = acc_w;
                if (r_r == LAST) begin
                    n_state = S_PASS_END;
                end else begin
                    n_r     = r_r + 1'b1;
                    n_state = S_ROW_RD;
                end
            end
            S_PASS_END: begin
                if (!r_changed || r_pass == i_max_steps) begin
                    n_val   = r_pass;
                    n_state = S_RESP;
                end else begin
                    n_pass    = r_pass + 1'b1;
                    n_changed = 1'b0;
                    n_r       = '0;
                    n_state   = S_ROW_RD;
                end
            end
            S_RESP: begin
                if (!r_o_valid || o_res.ready) begin
                    n_o_valid = 1'b1;
                    n_o_kind  = r_cmd.func;
                    n_o_value = r_val;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_adj_v   <= '0;
            r_hop_v   <= 1'b0;
            r_o_valid <= 1'b0;
            r_kd_v    <= 1'b0;
            r_changed <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_adj_v   <= n_adj_v;
            r_hop_v   <= n_hop_v;
            r_o_valid <= n_o_valid;
            r_kd_v    <= n_kd_v;
            r_changed <= n_changed;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_pass    <= n_pass;
        r_r       <= n_r;
        r_k       <= n_k;
        r_kd      <= n_kd;
        r_row     <= n_row;
        r_new     <= n_new;
        r_acc     <= n_acc;
        r_val     <= n_val;
        r_o_kind  <= n_o_kind;
        r_o_value <= n_o_value;
    end

    assign o_res.valid = r_o_valid;
    assign o_res.kind  = r_o_kind;
    assign o_res.value = r_o_value;

endmodule

// ----- design/bounded_hop_distance_matrix_unit.sv -----
// Bounded hop distance matrix.
// Command channel i_cmd (valid/ready): func, src_node, dst_node. One result beat per
// command on o_res (valid/ready): kind echoes func, value carries the answer.
//   clear : drops all edges and distances.
//   add   : sets edge src->dst by a row read-modify-write.
//   read  : hop distance of src->dst (0 = none or diagonal).
//   run   : all-pairs search, value = index of the last pass. Each pass walks every row
//           and, per row, every adjacency row through the single adjacency read port.
// Config: i_cfg_we/i_cfg_wdata load max_steps (reset 6); the user must load it only while
// no command is in flight, as the block itself does not enforce this.
// A two-beat queue in front takes commands while the back end works; the back end
// handles one command at a time. The result register holds its beat while o_res
// is stalled, and the next result waits behind it.
// Reset (synchronous, active low) empties the queue, drops the result, marks all
// adjacency rows and the distance store empty; no clearing pass is needed.
module bounded_hop_distance_matrix_unit import bhd_pkg::*; #(
    parameter int NODES = NODES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bhd_cmd_if.sink          i_cmd,
    bhd_res_if.source        o_res,
    input  logic             i_cfg_we,
    input  logic [VAL_W-1:0] i_cfg_wdata
);

    logic [VAL_W-1:0] r_max_steps;
    logic             w_q_valid;
    logic             w_pop;
    t_cmd             w_q_cmd;

    // max_steps register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_steps <= MAX_STEPS_RST;
        end else if (i_cfg_we) begin
            r_max_steps <= i_cfg_wdata;
        end
    end

    // front: accept and range-check, queue
    bhd_front #(.NODES(NODES)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (i_cmd),
        .i_pop     (w_pop),
        .o_q_valid (w_q_valid),
        .o_q_cmd   (w_q_cmd)
    );

    // back: graph store, search sequencer, result register
    bhd_back #(.NODES(NODES)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_max_steps (r_max_steps),
        .i_q_valid   (w_q_valid),
        .i_q_cmd     (w_q_cmd),
        .o_pop       (w_pop),
        .o_res       (o_res)
    );

    // back end never pops an empty queue
    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("pop from empty command queue");

    // one command at a time: two pops never come back to back
    a_pop_spaced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> !w_pop)
        else $error("back end took two commands in a row");

    // clear and add always answer 0
    a_plain_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.kind == FN_CLEAR || o_res.kind == FN_ADD))
            |-> (o_res.value == '0))
        else $error("clear/add result carries nonzero value");

endmodule

// ----- bench/hop_distance_checker.sv -----
module hop_distance_checker import bhd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bhd_cmd_if               cmd,
    bhd_res_if               res,
    input  logic             i_cfg_we,
    input  logic [VAL_W-1:0] i_cfg_wdata,
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct packed {
        logic [FUNC_W-1:0] kind;
        logic [VAL_W-1:0]  value;
    } t_answer;

    logic [63:0]      edge_rows [64];
    logic [VAL_W-1:0] hops [64][64];
    logic [VAL_W-1:0] step_limit;
    t_answer          answers_due [$];

    // breadth passes over the power pattern; returns the index of the last pass
    function automatic logic [VAL_W-1:0] search_hops();
        logic [63:0] power [64];
        logic [63:0] grown [64];
        int          last;
        bit          changed;
        last = 0;
        foreach (hops[r, c]) hops[r][c] = '0;
        power = edge_rows;
        for (int pass = 1; pass <= int'(step_limit); pass++) begin
            changed = 0;
            for (int r = 0; r < 64; r++) begin
                for (int c = 0; c < 64; c++) begin
                    if (r != c && power[r][c] && hops[r][c] == '0) begin
                        hops[r][c] = VAL_W'(pass);
                        changed    = 1;
                    end
                end
            end
            last = pass;
            if (!changed || pass == int'(step_limit)) break;
            for (int r = 0; r < 64; r++) begin
                grown[r] = '0;
                for (int k = 0; k < 64; k++) begin
                    if (power[r][k]) grown[r] |= edge_rows[k];
                end
            end
            power = grown;
        end
        return VAL_W'(last);
    endfunction

    function automatic t_answer predict(logic [FUNC_W-1:0] f, logic [IDX_W-1:0] s,
                                        logic [IDX_W-1:0] d);
        t_answer a;
        a.kind  = f;
        a.value = '0;
        case (f)
            FN_CLEAR: begin
                foreach (edge_rows[r]) edge_rows[r] = '0;
                foreach (hops[r, c]) hops[r][c] = '0;
            end
            FN_ADD:  edge_rows[s][d] = 1'b1;
            FN_RUN:  a.value = search_hops();
            default: a.value = hops[s][d];
        endcase
        return a;
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            foreach (edge_rows[r]) edge_rows[r] = '0;
            foreach (hops[r, c]) hops[r][c] = '0;
            step_limit = MAX_STEPS_RST;
            answers_due.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) step_limit = i_cfg_wdata;
            if (res.valid && res.ready) begin
                if (answers_due.size() == 0) begin
                    $error("result beat with nothing expected: kind %0d value %0d",
                           res.kind, res.value);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = answers_due.pop_front();
                    if (res.kind !== want.kind || res.value !== want.value) begin
                        if (res.kind !== want.kind)
                            $error("kind: expected %0d, got %0d", want.kind, res.kind);
                        if (res.value !== want.value)
                            $error("value: expected %0d, got %0d", want.value, res.value);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (cmd.valid && cmd.ready)
                answers_due.insert(answers_due.size(),
                                   predict(cmd.func, cmd.src_node, cmd.dst_node));
        end
        o_pending <= answers_due.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

endmodule

// ----- bench/testbench.sv -----
module testbench;
    import bhd_pkg::*;

    // longest quiet spell allowed
    localparam int QUIET_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    logic [VAL_W-1:0] cfg_wdata;
    int               fail_count;
    int               pending;

    // idle shaping, percent of cycles
    int gap_pct;
    int stall_pct;
    // hold-off requests; the receiver process keeps its own count
    int hold_asked;
    int hold_served;
    int hold_left;
    int quiet;
    int sent;

    bhd_cmd_if cmd ();
    bhd_res_if res ();

    bounded_hop_distance_matrix_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_res       (res),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    hop_distance_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .cmd          (cmd),
        .res          (res),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side: random stalls, plus long hold-offs on request so the
    // front queue fills and the block drops i_cmd.ready
    always @(posedge i_clk) begin
        if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            res.ready <= 1'b0;
        end else begin
            res.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog: cycles with no beat on either channel
    always @(posedge i_clk) begin
        if ((cmd.valid && cmd.ready) || (res.valid && res.ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("** bounded_hop_distance_matrix_unit: FAILED **");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // one command beat; valid stays high across back-to-back beats
    task automatic send(logic [FUNC_W-1:0] f, logic [IDX_W-1:0] s, logic [IDX_W-1:0] d);
        while ($urandom_range(99) < gap_pct) begin
            cmd.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd.valid    <= 1'b1;
        cmd.func     <= f;
        cmd.src_node <= s;
        cmd.dst_node <= d;
        do @(posedge i_clk); while (!cmd.ready);
        sent++;
    endtask

    // max_steps only changes with nothing in flight
    task automatic set_steps(logic [VAL_W-1:0] v);
        cmd.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // well-formed job: maybe clear, build a small graph in a window of
    // eight nodes, run it, read pairs back; then a little noise
    task automatic job();
        logic [IDX_W-1:0] base;
        int               n;
        base = IDX_W'($urandom_range(0, 56));
        if ($urandom_range(2) == 0) send(FN_CLEAR, '0, '0);
        n = $urandom_range(1, 12);
        repeat (n) send(FN_ADD, base + IDX_W'($urandom_range(7)),
                        base + IDX_W'($urandom_range(7)));
        send(FN_RUN, IDX_W'($urandom), IDX_W'($urandom));
        n = $urandom_range(6, 16);
        repeat (n) send(FN_READ, base + IDX_W'($urandom_range(7)),
                        base + IDX_W'($urandom_range(7)));
        n = $urandom_range(0, 3);
        repeat (n) begin
            case ($urandom_range(2))
                0:       send(FN_CLEAR, IDX_W'($urandom), IDX_W'($urandom));
                1:       send(FN_ADD, IDX_W'($urandom), IDX_W'($urandom));
                default: send(FN_READ, IDX_W'($urandom), IDX_W'($urandom));
            endcase
        end
    endtask

    initial begin
        int steps_pick [4];
        steps_pick   = '{1, 3, 2, 6};
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        cmd.valid    = 1'b0;
        cmd.func     = FN_CLEAR;
        cmd.src_node = '0;
        cmd.dst_node = '0;
        res.ready    = 1'b0;
        gap_pct      = 0;
        stall_pct    = 0;
        hold_asked   = 0;
        hold_served  = 0;
        hold_left    = 0;
        quiet        = 0;
        sent         = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset distances, cycle, self edge, repeated edge, top nodes
        send(FN_READ, 6'd0, 6'd0);
        send(FN_ADD, 6'd0, 6'd1);
        send(FN_ADD, 6'd1, 6'd2);
        send(FN_ADD, 6'd2, 6'd0);
        send(FN_ADD, 6'd3, 6'd3);
        send(FN_ADD, 6'd0, 6'd1);
        send(FN_ADD, 6'd63, 6'd62);
        send(FN_RUN, 6'd0, 6'd0);
        send(FN_READ, 6'd0, 6'd2);
        send(FN_READ, 6'd0, 6'd0);
        send(FN_READ, 6'd3, 6'd3);
        send(FN_READ, 6'd63, 6'd62);
        send(FN_READ, 6'd62, 6'd63);
        send(FN_CLEAR, 6'd63, 6'd63);
        send(FN_READ, 6'd0, 6'd1);
        // zero max_steps: no pass at all
        send(FN_ADD, 6'd4, 6'd5);
        set_steps(6'd0);
        send(FN_RUN, 6'd0, 6'd0);
        send(FN_READ, 6'd4, 6'd5);
        // widest setting on a chain 10..19, stops early
        set_steps(6'd63);
        for (int i = 10; i < 19; i++) send(FN_ADD, IDX_W'(i), IDX_W'(i + 1));
        send(FN_RUN, 6'd0, 6'd0);
        send(FN_READ, 6'd10, 6'd19);

        for (int ph = 0; ph < 4; ph++) begin
            set_steps(VAL_W'(steps_pick[ph]));
            case (ph)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 47; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 47; end
                default: begin gap_pct = 21; stall_pct = 21; end
            endcase
            // sender keeps offering during a long result hold-off
            if (ph == 0) hold_asked++;
            while (sent < 25 + 160 * (ph + 1)) job();
        end

        cmd.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** bounded_hop_distance_matrix_unit: PASSED **");
        end else begin
            $display("** bounded_hop_distance_matrix_unit: FAILED **");
        end
        $finish;
    end

endmodule
